[hw/rtl/ir_pulse_distance_transmitter_macros.svh]
// ----------------------------------------------------------------------------
// ir pulse distance transmitter assertion macros
// property wrappers for the checker file
// ----------------------------------------------------------------------------
`ifndef IR_PULSE_DISTANCE_TRANSMITTER_MACROS_SVH
`define IR_PULSE_DISTANCE_TRANSMITTER_MACROS_SVH

// same-cycle implication, disabled during reset
`define IRPDT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("irpdt assertion failed");

// next-cycle implication, disabled during reset
`define IRPDT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("irpdt assertion failed");

`endif

[hw/rtl/irpdt_pkg.sv]
// ----------------------------------------------------------------------------
// irpdt_pkg
// shared constants, types and helper functions of the ir transmitter
// ----------------------------------------------------------------------------
`default_nettype none

package irpdt_pkg;

    // frame geometry
    localparam int DATA_BITS  = 16;
    localparam int CHECK_BITS = 8;
    localparam int FRAME_BITS = DATA_BITS + CHECK_BITS;
    localparam int TIMER_BITS = 16;
    localparam int BITS_W     = $clog2(FRAME_BITS + 1);
    localparam int WORD_W     = 16;
    localparam int DUR_W      = 16;
    localparam int PAD_W      = DATA_BITS + 2 * CHECK_BITS;

    localparam logic [32:0] TIMER_MAX_W = (33'd1 << TIMER_BITS) - 33'd1;

    // phase codes
    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_START_HIGH = 3'd1;
    localparam logic [2:0] PH_START_LOW  = 3'd2;
    localparam logic [2:0] PH_MARK       = 3'd3;
    localparam logic [2:0] PH_SPACE      = 3'd4;

    // register indexes
    localparam logic [2:0] REG_START_HIGH = 3'd0;
    localparam logic [2:0] REG_START_LOW  = 3'd1;
    localparam logic [2:0] REG_ONE_HIGH   = 3'd2;
    localparam logic [2:0] REG_ONE_LOW    = 3'd3;
    localparam logic [2:0] REG_ZERO_HIGH  = 3'd4;
    localparam logic [2:0] REG_ZERO_LOW   = 3'd5;

    // register reset values
    localparam logic [DUR_W-1:0] RST_START_HIGH = 16'd2400;
    localparam logic [DUR_W-1:0] RST_START_LOW  = 16'd800;
    localparam logic [DUR_W-1:0] RST_ONE_HIGH   = 16'd1600;
    localparam logic [DUR_W-1:0] RST_ONE_LOW    = 16'd800;
    localparam logic [DUR_W-1:0] RST_ZERO_HIGH  = 16'd800;
    localparam logic [DUR_W-1:0] RST_ZERO_LOW   = 16'd1600;

    // duration settings handed to the core
    typedef struct packed {
        logic [DUR_W-1:0] start_high;
        logic [DUR_W-1:0] start_low;
        logic [DUR_W-1:0] one_high;
        logic [DUR_W-1:0] one_low;
        logic [DUR_W-1:0] zero_high;
        logic [DUR_W-1:0] zero_low;
    } cfg_t;

    // per-item result flags
    typedef struct packed {
        logic frame_done;
        logic accepted;
        logic busy_res;
        logic ir_level;
    } res_t;

    // zero counts as one, values past the timer range saturate
    function automatic logic [TIMER_BITS-1:0] load_duration(input logic [DUR_W-1:0] v);
        logic [32:0] wide;
        wide = {17'd0, v};
        if (wide == 33'd0)
        begin
            wide = 33'd1;
        end
        if (wide > TIMER_MAX_W)
        begin
            wide = TIMER_MAX_W;
        end
        return wide[TIMER_BITS-1:0];
    endfunction

    // data bits followed by check bits, check bit i = data[i] ^ data[i+CHECK_BITS]
    function automatic logic [FRAME_BITS-1:0] build_frame(input logic [WORD_W-1:0] word);
        logic [DATA_BITS-1:0]  data;
        logic [PAD_W-1:0]      padded;
        logic [CHECK_BITS-1:0] check;
        data   = DATA_BITS'(word);
        padded = PAD_W'(data);
        for (int i = 0; i < CHECK_BITS; i++)
        begin
            check[i] = padded[i] ^ padded[i + CHECK_BITS];
        end
        return {data, check};
    endfunction

endpackage

`default_nettype wire

[hw/rtl/irpdt_regs.sv]
// ----------------------------------------------------------------------------
// irpdt_regs
// apb register file holding the six tick durations
// ----------------------------------------------------------------------------
`default_nettype none

module irpdt_regs (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [4:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready,
    output irpdt_pkg::cfg_t           cfg
);

    irpdt_pkg::cfg_t cfg_reg;
    irpdt_pkg::cfg_t cfg_next;
    logic            wr_en;
    logic [2:0]      reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    // write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                irpdt_pkg::REG_START_HIGH: cfg_next.start_high = pwdata[15:0];
                irpdt_pkg::REG_START_LOW:  cfg_next.start_low  = pwdata[15:0];
                irpdt_pkg::REG_ONE_HIGH:   cfg_next.one_high   = pwdata[15:0];
                irpdt_pkg::REG_ONE_LOW:    cfg_next.one_low    = pwdata[15:0];
                irpdt_pkg::REG_ZERO_HIGH:  cfg_next.zero_high  = pwdata[15:0];
                irpdt_pkg::REG_ZERO_LOW:   cfg_next.zero_low   = pwdata[15:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    // register storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_high <= irpdt_pkg::RST_START_HIGH;
            cfg_reg.start_low  <= irpdt_pkg::RST_START_LOW;
            cfg_reg.one_high   <= irpdt_pkg::RST_ONE_HIGH;
            cfg_reg.one_low    <= irpdt_pkg::RST_ONE_LOW;
            cfg_reg.zero_high  <= irpdt_pkg::RST_ZERO_HIGH;
            cfg_reg.zero_low   <= irpdt_pkg::RST_ZERO_LOW;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_idx)
            irpdt_pkg::REG_START_HIGH: prdata = {16'd0, cfg_reg.start_high};
            irpdt_pkg::REG_START_LOW:  prdata = {16'd0, cfg_reg.start_low};
            irpdt_pkg::REG_ONE_HIGH:   prdata = {16'd0, cfg_reg.one_high};
            irpdt_pkg::REG_ONE_LOW:    prdata = {16'd0, cfg_reg.one_low};
            irpdt_pkg::REG_ZERO_HIGH:  prdata = {16'd0, cfg_reg.zero_high};
            irpdt_pkg::REG_ZERO_LOW:   prdata = {16'd0, cfg_reg.zero_low};
            default:                   prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/irpdt_core.sv]
// ----------------------------------------------------------------------------
// irpdt_core
// frame state and tick timer, one request or tick per transfer
// ----------------------------------------------------------------------------
`default_nettype none

module irpdt_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_fire,
    input  wire logic                                action,
    input  wire logic [irpdt_pkg::WORD_W-1:0]        data_word,
    input  wire irpdt_pkg::cfg_t                     cfg,
    output irpdt_pkg::res_t                          res
);

    localparam int FB = irpdt_pkg::FRAME_BITS;
    localparam int TB = irpdt_pkg::TIMER_BITS;
    localparam int BW = irpdt_pkg::BITS_W;

    logic [2:0]    phase_reg,     phase_next;
    logic [FB-1:0] shift_reg,     shift_next;
    logic [BW-1:0] bits_left_reg, bits_left_next;
    logic [TB-1:0] timer_reg,     timer_next;
    logic [TB-1:0] space_reg,     space_next;

    logic [TB-1:0] timer_dec;
    logic [BW-1:0] bits_dec;
    logic [TB-1:0] one_hi_d, one_lo_d, zero_hi_d, zero_lo_d;
    logic          accepted;
    logic          done;

    // clamped durations
    assign one_hi_d  = irpdt_pkg::load_duration(cfg.one_high);
    assign one_lo_d  = irpdt_pkg::load_duration(cfg.one_low);
    assign zero_hi_d = irpdt_pkg::load_duration(cfg.zero_high);
    assign zero_lo_d = irpdt_pkg::load_duration(cfg.zero_low);
    assign timer_dec = timer_reg - TB'(1);
    assign bits_dec  = bits_left_reg - BW'(1);

    // next state for one item
    always_comb
    begin
        phase_next     = phase_reg;
        shift_next     = shift_reg;
        bits_left_next = bits_left_reg;
        timer_next     = timer_reg;
        space_next     = space_reg;
        accepted       = 1'b0;
        done           = 1'b0;
        if (action)
        begin
            // send request, only taken while idle
            if (phase_reg == irpdt_pkg::PH_IDLE)
            begin
                shift_next     = irpdt_pkg::build_frame(data_word);
                bits_left_next = BW'(FB);
                timer_next     = irpdt_pkg::load_duration(cfg.start_high);
                space_next     = '0;
                phase_next     = irpdt_pkg::PH_START_HIGH;
                accepted       = 1'b1;
            end
        end
        else if (phase_reg != irpdt_pkg::PH_IDLE)
        begin
            // tick while a frame is in progress
            timer_next = timer_dec;
            if (timer_dec == '0)
            begin
                unique case (phase_reg)
                    irpdt_pkg::PH_START_HIGH:
                    begin
                        timer_next = irpdt_pkg::load_duration(cfg.start_low);
                        phase_next = irpdt_pkg::PH_START_LOW;
                    end
                    irpdt_pkg::PH_START_LOW:
                    begin
                        timer_next = shift_reg[FB-1] ? one_hi_d : zero_hi_d;
                        space_next = shift_reg[FB-1] ? one_lo_d : zero_lo_d;
                        phase_next = irpdt_pkg::PH_MARK;
                    end
                    irpdt_pkg::PH_MARK:
                    begin
                        timer_next = space_reg;
                        phase_next = irpdt_pkg::PH_SPACE;
                    end
                    irpdt_pkg::PH_SPACE:
                    begin
                        bits_left_next = bits_dec;
                        if (bits_dec == '0)
                        begin
                            phase_next = irpdt_pkg::PH_IDLE;
                            done       = 1'b1;
                        end
                        else
                        begin
                            // next bit moves up to the msb
                            shift_next = shift_reg << 1;
                            timer_next = shift_reg[FB-2] ? one_hi_d : zero_hi_d;
                            space_next = shift_reg[FB-2] ? one_lo_d : zero_lo_d;
                            phase_next = irpdt_pkg::PH_MARK;
                        end
                    end
                    default:
                    begin
                        phase_next = irpdt_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    // result flags from the updated phase
    always_comb
    begin
        res.ir_level   = (phase_next == irpdt_pkg::PH_START_HIGH) ||
                         (phase_next == irpdt_pkg::PH_MARK);
        res.busy_res   = (phase_next != irpdt_pkg::PH_IDLE);
        res.accepted   = accepted;
        res.frame_done = done;
    end

    // state registers, advanced on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= irpdt_pkg::PH_IDLE;
            shift_reg     <= '0;
            bits_left_reg <= '0;
            timer_reg     <= '0;
            space_reg     <= '0;
        end
        else if (in_fire)
        begin
            phase_reg     <= phase_next;
            shift_reg     <= shift_next;
            bits_left_reg <= bits_left_next;
            timer_reg     <= timer_next;
            space_reg     <= space_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/ir_pulse_distance_transmitter.sv]
// ----------------------------------------------------------------------------
// ir_pulse_distance_transmitter
// the result of each input transfer is registered in the output register
// throughput: one item per cycle unless the output stalls, set by the single state update in the core
// the output register holds a result while the input side keeps taking items
// as long as the result is consumed in the same cycle
// reset: asynchronous active low, idle line, durations at their defaults
// ----------------------------------------------------------------------------
`default_nettype none

module ir_pulse_distance_transmitter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // apb configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] data_word
    input  wire logic        s_axis_tuser,   // [0] action
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [7:0]  m_axis_tdata    // [0] ir_level, [1] busy_res,
                                             // [2] accepted, [3] frame_done
);

    irpdt_pkg::cfg_t cfg;
    irpdt_pkg::res_t res;
    irpdt_pkg::res_t res_reg;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            in_fire;

    // take a new item whenever the output slot frees up this cycle
    assign s_axis_tready  = !out_valid_reg || m_axis_tready;
    assign in_fire        = s_axis_tvalid && s_axis_tready;
    assign out_valid_next = in_fire || (out_valid_reg && !m_axis_tready);

    irpdt_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    irpdt_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .action    (s_axis_tuser),
        .data_word (s_axis_tdata),
        .cfg       (cfg),
        .res       (res)
    );

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, res_reg.frame_done, res_reg.accepted,
                            res_reg.busy_res, res_reg.ir_level};

endmodule

`default_nettype wire

[hw/rtl/irpdt_checker.sv]
// ----------------------------------------------------------------------------
// irpdt_checker
// port-level checks of the transmitter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "ir_pulse_distance_transmitter_macros.svh"

module irpdt_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       m_axis_tvalid,
    input  wire logic       m_axis_tready,
    input  wire logic [7:0] m_axis_tdata
);

    // a stalled result stays put
    `IRPDT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // the frame end leaves the line dark and the block idle
    `IRPDT_ASSERT_NOW(a_done_idle, m_axis_tvalid && m_axis_tdata[3], !m_axis_tdata[1] && !m_axis_tdata[0])

    // a started frame begins with the start pulse high
    `IRPDT_ASSERT_NOW(a_accept_high, m_axis_tvalid && m_axis_tdata[2], m_axis_tdata[1] && m_axis_tdata[0])

    // the emitter is only on inside a frame
    `IRPDT_ASSERT_NOW(a_level_busy, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[1])

endmodule

bind ir_pulse_distance_transmitter irpdt_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
